[hdl/nss_pkg.sv]
package nss_pkg;

  localparam int MAX_SEGMENTS_DEF = 32;
  localparam int COORD_BITS_DEF   = 10;
  localparam int OUT_IDX_BITS     = 5;
  localparam int OUT_DATA_BITS    = 8;

  typedef enum logic [1:0] {
    MODE_ADD      = 2'd0,
    MODE_CLEAR    = 2'd1,
    MODE_ENDPOINT = 2'd2,
    MODE_LINE     = 2'd3
  } mode_t;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

endpackage

[hdl/nearest_segment_search_unit.sv]
// Add and clear go straight to the result. An endpoint query steps each stored segment
// via S_RD, S_LD, S_E1-S_E5; a line query via S_RD, S_LD, S_LAD-S_LCHK, maybe S_LM2-S_LDEC.
// One shared signed multiplier with a registered product does every multiply, one per cycle.
// Throughput: one word in flight; input is taken again once the result is in the output register.
// Reset (rst, synchronous): empties the table and drops any pending result; table contents
// stay undefined until written.
module nearest_segment_search_unit
  import nss_pkg::*;
#(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  // first_x, first_y, second_x, second_y from bit 0 up, zero padded to bytes
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]         s_tdata,
  // mode
  input  logic [1:0]                                s_tuser,
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  // nearest_index, zero padded to a byte
  output logic [OUT_DATA_BITS-1:0]                  m_tdata,
  // status
  output logic                                      m_tuser
);

  localparam int C  = COORD_BITS;
  localparam int D  = C + 1;
  localparam int W  = 2 * C + 2;
  localparam int SW = W + 1;
  localparam int PW = 2 * SW;
  localparam int LW = 3 * W;
  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_LD,
    S_E1, S_E2, S_E3, S_E4, S_E5,
    S_LAD, S_LBD, S_LAA, S_LBB, S_LSQ, S_LCHK, S_LM2, S_LM3, S_LM4, S_LCMP, S_LDEC,
    S_FIN
  } state_t;

  state_t                  state;
  logic [CW-1:0]           count;
  logic [IW-1:0]           idx;
  logic [IW-1:0]           best;
  logic                    have;
  logic                    line_q;
  logic                    res_status;

  logic [4*C-1:0]          mem [MAX_SEGMENTS];
  logic [4*C-1:0]          rd;

  logic [C-1:0]            px;
  logic [C-1:0]            py;
  logic signed [D-1:0]     ea;
  logic signed [D-1:0]     eb;
  logic signed [D-1:0]     e1x;
  logic signed [D-1:0]     e1y;
  logic signed [D-1:0]     e2x;
  logic signed [D-1:0]     e2y;

  logic signed [SW-1:0]    mul_a;
  logic signed [SW-1:0]    mul_b;
  logic signed [PW-1:0]    prod;
  logic signed [PW-1:0]    acc;
  logic signed [PW-1:0]    num;
  logic [W-1:0]            an;
  logic [W-1:0]            den;
  logic [2*W-1:0]          n2;
  logic [2*W-1:0]          bn;
  logic [W-1:0]            bd;
  logic [W-1:0]            dist_best;
  logic [LW-1:0]           lhs;
  logic [LW-1:0]           rhs;

  mode_t                   in_mode;
  logic                    in_fire;
  logic                    table_full;
  logic                    last_seg;
  logic [W-1:0]            dsum;
  logic [LW-1:0]           prod_ext;

  assign in_mode    = mode_t'(s_tuser);
  assign s_tready   = (state == S_IDLE);
  assign in_fire    = s_tvalid && s_tready;
  assign table_full = (count == CW'(MAX_SEGMENTS));
  assign last_seg   = ((CW'(idx) + CW'(1)) == count);
  assign dsum       = W'(acc + prod);
  assign prod_ext   = LW'(prod[2*W-1:0]);

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_E1: begin
        mul_a = SW'(e1x);
        mul_b = SW'(e1x);
      end
      S_E2: begin
        mul_a = SW'(e1y);
        mul_b = SW'(e1y);
      end
      S_E3: begin
        mul_a = SW'(e2x);
        mul_b = SW'(e2x);
      end
      S_E4: begin
        mul_a = SW'(e2y);
        mul_b = SW'(e2y);
      end
      S_LAD: begin
        mul_a = SW'(ea);
        mul_b = SW'(e1x);
      end
      S_LBD: begin
        mul_a = SW'(eb);
        mul_b = SW'(e1y);
      end
      S_LAA: begin
        mul_a = SW'(ea);
        mul_b = SW'(ea);
      end
      S_LBB: begin
        mul_a = SW'(eb);
        mul_b = SW'(eb);
      end
      S_LSQ: begin
        mul_a = SW'(an);
        mul_b = SW'(an);
      end
      S_LCHK: begin
        mul_a = SW'(prod[W-1:0]);
        mul_b = SW'(bd);
      end
      S_LM2: begin
        mul_a = SW'(n2[2*W-1:W]);
        mul_b = SW'(bd);
      end
      S_LM3: begin
        mul_a = SW'(bn[W-1:0]);
        mul_b = SW'(den);
      end
      S_LM4: begin
        mul_a = SW'(bn[2*W-1:W]);
        mul_b = SW'(den);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_mode == MODE_ADD && !table_full) begin
      mem[count[IW-1:0]] <= s_tdata[4*C-1:0];
    end
    rd <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      idx      <= '0;
      best     <= '0;
      have     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_FIN) begin
        m_tvalid <= 1'b0;
      end
      prod <= mul_a * mul_b;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            px         <= s_tdata[C-1:0];
            py         <= s_tdata[2*C-1:C];
            idx        <= '0;
            best       <= '0;
            have       <= 1'b0;
            line_q     <= (in_mode == MODE_LINE);
            res_status <= STATUS_DONE;
            case (in_mode)
              MODE_ADD: begin
                if (table_full) begin
                  res_status <= STATUS_FULL;
                end else begin
                  count <= count + CW'(1);
                end
                state <= S_FIN;
              end
              MODE_CLEAR: begin
                count <= '0;
                state <= S_FIN;
              end
              MODE_ENDPOINT, MODE_LINE: begin
                state <= (count == '0) ? S_FIN : S_RD;
              end
              default: begin
                state <= S_FIN;
              end
            endcase
          end
        end
        S_RD: begin
          state <= S_LD;
        end
        S_LD: begin
          ea    <= $signed({1'b0, rd[4*C-1:3*C]}) - $signed({1'b0, rd[2*C-1:C]});
          eb    <= $signed({1'b0, rd[C-1:0]}) - $signed({1'b0, rd[3*C-1:2*C]});
          e1x   <= $signed({1'b0, px}) - $signed({1'b0, rd[C-1:0]});
          e1y   <= $signed({1'b0, py}) - $signed({1'b0, rd[2*C-1:C]});
          e2x   <= $signed({1'b0, px}) - $signed({1'b0, rd[3*C-1:2*C]});
          e2y   <= $signed({1'b0, py}) - $signed({1'b0, rd[4*C-1:3*C]});
          state <= line_q ? S_LAD : S_E1;
        end
        S_E1: begin
          state <= S_E2;
        end
        S_E2: begin
          acc   <= prod;
          state <= S_E3;
        end
        S_E3: begin
          if (!have || dsum < dist_best) begin
            dist_best <= dsum;
            best      <= idx;
            have      <= 1'b1;
          end
          state <= S_E4;
        end
        S_E4: begin
          acc   <= prod;
          state <= S_E5;
        end
        S_E5: begin
          if (dsum < dist_best) begin
            dist_best <= dsum;
            best      <= idx;
          end
          if (last_seg) begin
            state <= S_FIN;
          end else begin
            idx   <= idx + IW'(1);
            state <= S_RD;
          end
        end
        S_LAD: begin
          state <= S_LBD;
        end
        S_LBD: begin
          acc   <= prod;
          state <= S_LAA;
        end
        S_LAA: begin
          num   <= acc + prod;
          state <= S_LBB;
        end
        S_LBB: begin
          an    <= W'(num[PW-1] ? -num : num);
          acc   <= prod;
          state <= S_LSQ;
        end
        S_LSQ: begin
          den   <= dsum;
          state <= S_LCHK;
        end
        S_LCHK: begin
          n2 <= prod[2*W-1:0];
          if (den == '0 || !have) begin
            // skip a degenerate segment; take the first proper one
            if (den != '0) begin
              bn   <= prod[2*W-1:0];
              bd   <= den;
              best <= idx;
              have <= 1'b1;
            end
            if (last_seg) begin
              state <= S_FIN;
            end else begin
              idx   <= idx + IW'(1);
              state <= S_RD;
            end
          end else begin
            state <= S_LM2;
          end
        end
        S_LM2: begin
          lhs   <= prod_ext;
          state <= S_LM3;
        end
        S_LM3: begin
          lhs   <= lhs + (prod_ext << W);
          state <= S_LM4;
        end
        S_LM4: begin
          rhs   <= prod_ext;
          state <= S_LCMP;
        end
        S_LCMP: begin
          rhs   <= rhs + (prod_ext << W);
          state <= S_LDEC;
        end
        S_LDEC: begin
          if (lhs < rhs) begin
            bn   <= n2;
            bd   <= den;
            best <= idx;
          end
          if (last_seg) begin
            state <= S_FIN;
          end else begin
            idx   <= idx + IW'(1);
            state <= S_RD;
          end
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_DATA_BITS'(OUT_IDX_BITS'(best));
            m_tuser  <= res_status;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_SEGMENTS))
    else $error("segment count beyond table depth");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && state != S_FIN) |-> (CW'(idx) < count))
    else $error("table walk beyond stored segments");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_tready)
    else $error("input taken while a word is in flight");

  a_line_compare: assert property (@(posedge clk) disable iff (rst)
    (state == S_LDEC) |-> (have && den != '0))
    else $error("line compare without a proper best segment");

endmodule
